// ===== rtl/rbch_pkg.sv =====
// Shared types, register map and fixed-point helpers for the ray/box closest-hit block.
package rbch_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ID_W       = 16;
    localparam int DIST_W     = 31;
    localparam int SIZE_W     = 31;
    localparam int S_TDATA_W  = 208;
    localparam int M_TDATA_W  = 48;

    typedef logic signed [31:0] q16_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_ORIGIN_Z     = 3'd2,
        REG_RECIP_X      = 3'd3,
        REG_RECIP_Y      = 3'd4,
        REG_RECIP_Z      = 3'd5,
        REG_MAX_DISTANCE = 3'd6
    } reg_idx_t;

    localparam q16_t               ORIGIN_RESET = 32'sd0;
    localparam q16_t               RECIP_RESET  = 32'sd65536;
    localparam logic [DIST_W-1:0]  MAX_DIST_RESET = 31'd65536000;

    typedef struct packed {
        q16_t [2:0]        origin;
        q16_t [2:0]        recip;
        logic [DIST_W-1:0] max_distance;
    } cfg_t;

    // Box on its way from the input register to the nearest-hit tracker.
    typedef struct packed {
        logic            valid;
        logic            last;
        q16_t            tmin;
        q16_t            tmax;
        logic [ID_W-1:0] id;
    } cand_t;

    function automatic q16_t sat33(input logic signed [32:0] v);
        q16_t r;
        if (v[32] == v[31]) begin
            r = v[31:0];
        end else if (v[32]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // (corner - origin) * recip, divided by 2^16 toward zero, saturated.
    function automatic q16_t slab_t(input q16_t corner, input q16_t org, input q16_t recip);
        q16_t               d;
        logic signed [63:0] p;
        logic signed [63:0] biased;
        logic signed [47:0] q;
        q16_t               r;
        d      = sat33(33'(corner) - 33'(org));
        p      = 64'(d) * 64'(recip);
        biased = p + (p[63] ? 64'sd65535 : 64'sd0);
        q      = biased[63:FRAC_BITS];
        if (q[47:31] == {17{q[47]}}) begin
            r = q[31:0];
        end else if (q[47]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ===== rtl/rbch_cfg_regs.sv =====
// APB register bank holding the ray origin, reciprocal direction and maximum distance.
module rbch_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rbch_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rbch_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rbch_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output rbch_pkg::cfg_t                   cfg
);
    import rbch_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin       <= {3{ORIGIN_RESET}};
            cfg_reg.recip        <= {3{RECIP_RESET}};
            cfg_reg.max_distance <= MAX_DIST_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_ORIGIN_X:     cfg_reg.origin[0]    <= pwdata;
                REG_ORIGIN_Y:     cfg_reg.origin[1]    <= pwdata;
                REG_ORIGIN_Z:     cfg_reg.origin[2]    <= pwdata;
                REG_RECIP_X:      cfg_reg.recip[0]     <= pwdata;
                REG_RECIP_Y:      cfg_reg.recip[1]     <= pwdata;
                REG_RECIP_Z:      cfg_reg.recip[2]     <= pwdata;
                REG_MAX_DISTANCE: cfg_reg.max_distance <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ORIGIN_X:     prdata = cfg_reg.origin[0];
            REG_ORIGIN_Y:     prdata = cfg_reg.origin[1];
            REG_ORIGIN_Z:     prdata = cfg_reg.origin[2];
            REG_RECIP_X:      prdata = cfg_reg.recip[0];
            REG_RECIP_Y:      prdata = cfg_reg.recip[1];
            REG_RECIP_Z:      prdata = cfg_reg.recip[2];
            REG_MAX_DISTANCE: prdata = {1'b0, cfg_reg.max_distance};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== rtl/rbch_slab.sv =====
// One-axis slab: box corners from center and size, entry and exit distances along the ray.
module rbch_slab (
    input  rbch_pkg::q16_t                  center,
    input  logic [rbch_pkg::SIZE_W-1:0]     size,
    input  rbch_pkg::q16_t                  origin,
    input  rbch_pkg::q16_t                  recip,
    output rbch_pkg::q16_t                  t_near,
    output rbch_pkg::q16_t                  t_far
);
    import rbch_pkg::*;

    logic [SIZE_W-2:0] half;
    q16_t              lo;
    q16_t              hi;
    q16_t              t1;
    q16_t              t2;

    assign half = size[SIZE_W-1:1];
    assign lo   = sat33(33'(center) - $signed({3'b000, half}));
    assign hi   = sat33(33'(center) + $signed({3'b000, half}));
    assign t1   = slab_t(lo, origin, recip);
    assign t2   = slab_t(hi, origin, recip);

    assign t_near = (t1 < t2) ? t1 : t2;
    assign t_far  = (t1 < t2) ? t2 : t1;

endmodule

// ===== rtl/rbch_nearest.sv =====
// Running nearest-hit tracker per scan, with the result register on the output stream.
module rbch_nearest (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rbch_pkg::cand_t                 cand,
    input  logic [rbch_pkg::DIST_W-1:0]     max_distance,
    output logic                            cand_ready,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [rbch_pkg::ID_W-1:0]       res_id,
    output logic [rbch_pkg::DIST_W-1:0]     res_distance,
    output logic                            res_hit
);
    import rbch_pkg::*;

    logic              scan_open_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic              hit_reg;
    logic              res_valid_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic [DIST_W-1:0] res_dist_reg;
    logic              res_hit_reg;

    logic [DIST_W-1:0] base_dist;
    logic [ID_W-1:0]   base_id;
    logic              base_hit;
    logic              take;
    logic              step;
    logic [DIST_W-1:0] best_dist_next;
    logic [ID_W-1:0]   best_id_next;
    logic              hit_next;

    // Hold a last box while the previous result is still waiting.
    assign cand_ready = !(cand.last && res_valid_reg && !res_ready);
    assign step       = cand.valid && cand_ready;

    // A closed scan restarts from the current distance limit.
    assign base_dist = scan_open_reg ? best_dist_reg : max_distance;
    assign base_id   = scan_open_reg ? best_id_reg : '0;
    assign base_hit  = scan_open_reg && hit_reg;

    assign take = (cand.tmax >= cand.tmin) && (cand.tmax > 32'sd0) && (cand.tmin > 32'sd0)
               && (cand.tmin < $signed({1'b0, base_dist}));

    assign best_dist_next = take ? cand.tmin[DIST_W-1:0] : base_dist;
    assign best_id_next   = take ? cand.id : base_id;
    assign hit_next       = take || base_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_open_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                scan_open_reg <= !cand.last;
            end
            if (step && cand.last) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            best_dist_reg <= best_dist_next;
            best_id_reg   <= best_id_next;
            hit_reg       <= hit_next;
            if (cand.last) begin
                res_dist_reg <= best_dist_next;
                res_id_reg   <= best_id_next;
                res_hit_reg  <= hit_next;
            end
        end
    end

    assign res_valid    = res_valid_reg;
    assign res_id       = res_id_reg;
    assign res_distance = res_dist_reg;
    assign res_hit      = res_hit_reg;

endmodule

// ===== rtl/ray_box_closest_hit.sv =====
// Top level of the ray/box closest-hit picker: box register, slab test, nearest tracker.
// Boxes stream in one per cycle; each is registered, then all three axes of the slab test
// (six 32x32 multiplies) and the compare against the running nearest are done between the
// box register and the tracker, whose result registers load as a last box leaves. The
// sustained rate is one box per clock, set by that single multiply-and-update stage; a last
// box stalls only while the previous result has not yet been taken. A scan starts at the
// first box after reset or after a last box, from the max_distance register value at
// that moment. Register map (APB, 4-byte stride): origin x/y/z at 0x00-0x08, reciprocal
// direction x/y/z at 0x0C-0x14, max_distance at 0x18; all signed Q16.16 except
// max_distance, which is unsigned.
module ray_box_closest_hit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rbch_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rbch_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rbch_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // center_x[31:0], center_y[63:32], center_z[95:64], size_x[126:96],
    // size_y[157:127], size_z[188:158], entity_id[204:189], zero pad[207:205]
    input  logic [rbch_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,  // last_box
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // nearest_id[15:0], nearest_distance[46:16], zero pad[47]
    output logic [rbch_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser   // hit_found
);
    import rbch_pkg::*;

    cfg_t                 cfg;
    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    logic                 stage_last_reg;
    logic [S_TDATA_W-1:0] stage_data_reg;
    logic                 s_accept;
    logic                 cand_ready;
    cand_t                cand;
    q16_t [2:0]           t_near;
    q16_t [2:0]           t_far;
    q16_t                 tmin;
    q16_t                 tmax;
    logic [ID_W-1:0]      res_id;
    logic [DIST_W-1:0]    res_distance;
    logic                 res_hit;

    rbch_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = !stage_valid_reg || cand_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept) begin
            stage_valid_next = 1'b1;
        end else if (cand_ready) begin
            stage_valid_next = 1'b0;
        end else begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_data_reg <= s_tdata;
            stage_last_reg <= s_tlast;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbch_slab u_slab (
            .center (stage_data_reg[32*a +: 32]),
            .size   (stage_data_reg[96 + SIZE_W*a +: SIZE_W]),
            .origin (cfg.origin[a]),
            .recip  (cfg.recip[a]),
            .t_near (t_near[a]),
            .t_far  (t_far[a])
        );
    end

    always_comb begin
        tmin = t_near[0];
        tmax = t_far[0];
        for (int a = 1; a < 3; a++) begin
            if (t_near[a] > tmin) begin
                tmin = t_near[a];
            end
            if (t_far[a] < tmax) begin
                tmax = t_far[a];
            end
        end
    end

    assign cand.valid = stage_valid_reg;
    assign cand.last  = stage_last_reg;
    assign cand.tmin  = tmin;
    assign cand.tmax  = tmax;
    assign cand.id    = stage_data_reg[189 +: ID_W];

    rbch_nearest u_nearest (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cand         (cand),
        .max_distance (cfg.max_distance),
        .cand_ready   (cand_ready),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_id       (res_id),
        .res_distance (res_distance),
        .res_hit      (res_hit)
    );

    assign m_tdata = {1'b0, res_distance, res_id};
    assign m_tuser = res_hit;

`ifndef SYNTHESIS
    // Input backpressure only comes from a last box blocked behind an untaken result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (stage_valid_reg && stage_last_reg && m_tvalid && !m_tready))
        else $error("input stalled without a blocked last box");

    // No hit means no id was recorded.
    a_miss_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[ID_W-1:0] == '0))
        else $error("miss reported with nonzero id");

    // An accepted hit always lies strictly ahead of the origin.
    a_hit_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[ID_W +: DIST_W] != '0))
        else $error("hit reported at zero distance");

    // A result appears in the cycle after a last box leaves the box register.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && stage_last_reg && cand_ready) |=> m_tvalid)
        else $error("last box produced no result");
`endif

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the ray/box closest-hit picker: directed scans, then random scans.
`timescale 1ns / 100ps

module testbench;
    import rbch_pkg::*;

    localparam longint Q_ONE       = longint'(1) << FRAC_BITS;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483648;
    localparam longint SIZE_MAX    = 64'sd2147483647;
    localparam int     STALL_LIMIT = 2000;
    localparam int     DRAIN_WAIT  = 4;

    typedef struct packed {
        q16_t [2:0]              center;
        logic [2:0][SIZE_W-1:0]  size;
        logic [ID_W-1:0]         id;
        logic                    last;
    } box_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic              hit;
    } nearest_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // center_x, center_y, center_z, size_x, size_y, size_z, entity_id, zero pad
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;  // last_box
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // nearest_id, nearest_distance, zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;          // hit_found

    // ray registers as the picker should hold them
    longint ray_origin [3];
    longint ray_recip  [3];
    longint ray_max_dist;

    // running nearest-hit state of the open scan
    longint          best_dist;
    logic [ID_W-1:0] best_id;
    bit              scan_open;
    bit              hit_seen;

    nearest_t nearest_q [$];
    int       errors      = 0;
    int       send_idle   = 0;
    int       recv_stall  = 0;
    int       idle_cycles = 0;

    ray_box_closest_hit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint clamp32(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic longint slab_time(input longint corner, input longint org,
                                         input longint recip);
        longint d;
        d = clamp32(corner - org);
        return clamp32((d * recip) / Q_ONE);
    endfunction

    // Update the running nearest hit with one box; queue a result on the last box.
    function automatic void trace_box(input box_t b);
        longint tmin, tmax, c, half, t1, t2;
        int     a;
        tmin = Q_MIN;
        tmax = Q_MAX;
        if (!scan_open) begin
            best_dist = ray_max_dist;
            best_id   = '0;
            hit_seen  = 1'b0;
            scan_open = 1'b1;
        end
        for (a = 0; a < 3; a++) begin
            c    = longint'($signed(b.center[a]));
            half = longint'(b.size[a]) >> 1;
            t1   = slab_time(clamp32(c - half), ray_origin[a], ray_recip[a]);
            t2   = slab_time(clamp32(c + half), ray_origin[a], ray_recip[a]);
            if (t1 > t2) begin
                c  = t1;
                t1 = t2;
                t2 = c;
            end
            if (t1 > tmin) tmin = t1;
            if (t2 < tmax) tmax = t2;
        end
        if (tmax >= tmin && tmax > 0 && tmin > 0 && tmin < best_dist) begin
            best_dist = tmin;
            best_id   = b.id;
            hit_seen  = 1'b1;
        end
        if (b.last) begin
            nearest_q.push_back('{id: best_id, distance: best_dist[DIST_W-1:0],
                                  hit: hit_seen});
            scan_open = 1'b0;
        end
    endfunction

    function automatic box_t mk_box(input longint cx, input longint cy, input longint cz,
                                    input longint sx, input longint sy, input longint sz,
                                    input int id, input bit last);
        box_t b;
        b.center[0] = cx[31:0];
        b.center[1] = cy[31:0];
        b.center[2] = cz[31:0];
        b.size[0]   = sx[SIZE_W-1:0];
        b.size[1]   = sy[SIZE_W-1:0];
        b.size[2]   = sz[SIZE_W-1:0];
        b.id        = id[ID_W-1:0];
        b.last      = last;
        return b;
    endfunction

    // cube of side sz centered at (cx, cy, cz), all in whole units
    function automatic box_t box_at(input int cx, input int cy, input int cz, input int sz,
                                    input int id, input bit last);
        return mk_box(cx * Q_ONE, cy * Q_ONE, cz * Q_ONE, sz * Q_ONE, sz * Q_ONE,
                      sz * Q_ONE, id, last);
    endfunction

    function automatic box_t random_box(input bit last);
        box_t   b;
        longint t, dir, c, sz;
        int     a, kind;
        kind = $urandom_range(0, 99);
        t    = longint'($urandom_range(0, 200 * 65536));
        for (a = 0; a < 3; a++) begin
            if (kind < 60) begin
                // place the box near the ray at a random distance
                dir = (ray_recip[a] == 0) ? 0 : (longint'(1) << 32) / ray_recip[a];
                c   = ray_origin[a] + ((t * dir) >>> FRAC_BITS)
                      + longint'($urandom_range(0, 8 * 65536)) - 4 * Q_ONE;
                sz  = longint'($urandom_range(0, 40 * 65536));
            end else if (kind < 75) begin
                c  = ray_origin[a] + longint'($urandom_range(0, 100 * 65536)) - 50 * Q_ONE;
                sz = longint'($urandom_range(0, 100 * 65536));
            end else if (kind < 90) begin
                c  = longint'($signed($urandom));
                sz = longint'($urandom) & SIZE_MAX;
            end else begin
                case ($urandom_range(0, 3))
                    0: c = Q_MIN;
                    1: c = Q_MAX;
                    2: c = 0;
                    default: c = longint'($signed($urandom));
                endcase
                case ($urandom_range(0, 2))
                    0: sz = 0;
                    1: sz = SIZE_MAX;
                    default: sz = longint'($urandom) & SIZE_MAX;
                endcase
            end
            c           = clamp32(c);
            b.center[a] = c[31:0];
            b.size[a]   = sz[SIZE_W-1:0];
        end
        b.id   = ID_W'($urandom_range(1, 65535));
        b.last = last;
        return b;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < 100)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
        errors++;
    endtask

    task automatic send_box(input box_t b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, b.id, b.size[2], b.size[1], b.size[0],
                     b.center[2], b.center[1], b.center[0]};
        s_tlast  <= b.last;
        do @(posedge aclk); while (!s_tready);
        trace_box(b);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (nearest_q.size() != 0);
    endtask

    // drain results, then let the pipeline empty of boxes that give no result
    task automatic settle();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r) inside
            REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z:
                ray_origin[int'(r)] = longint'($signed(v));
            REG_RECIP_X, REG_RECIP_Y, REG_RECIP_Z:
                ray_recip[int'(r) - int'(REG_RECIP_X)] = longint'($signed(v));
            default:
                ray_max_dist = longint'(v[DIST_W-1:0]);
        endcase
        @(posedge aclk);
    endtask

    task automatic load_ray(input q16_t ox, input q16_t oy, input q16_t oz, input q16_t rx,
                            input q16_t ry, input q16_t rz, input logic [DIST_W-1:0] md);
        settle();
        cfg_write(REG_ORIGIN_X, ox);
        cfg_write(REG_ORIGIN_Y, oy);
        cfg_write(REG_ORIGIN_Z, oz);
        cfg_write(REG_RECIP_X, rx);
        cfg_write(REG_RECIP_Y, ry);
        cfg_write(REG_RECIP_Z, rz);
        cfg_write(REG_MAX_DISTANCE, {1'b0, md});
    endtask

    task automatic pick_ray();
        q16_t              o [3];
        q16_t              r [3];
        logic [DIST_W-1:0] md;
        int                a;
        for (a = 0; a < 3; a++) begin
            if ($urandom_range(0, 99) < 80)
                o[a] = q16_t'($urandom_range(0, 200 * 65536) - 100 * 65536);
            else
                o[a] = q16_t'($urandom);
            case ($urandom_range(0, 6))
                0: r[a] = RECIP_RESET;
                1: r[a] = -RECIP_RESET;
                2: r[a] = RECIP_RESET / 2;
                3: r[a] = RECIP_RESET * 2;
                4: r[a] = 32'sh7FFF_FFFF;
                5: r[a] = 32'sh8000_0001;
                default: r[a] = q16_t'($urandom);
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: md = DIST_W'($urandom_range(0, 300 * 65536));
            5, 6, 7:       md = MAX_DIST_RESET;
            default:       md = DIST_W'($urandom);
        endcase
        load_ray(o[0], o[1], o[2], r[0], r[1], r[2], md);
    endtask

    // scans under the reset ray: origin 0, direction (1, 1, 1), max distance 1000
    task automatic test_reset_ray();
        send_box(box_at(10, 10, 10, 2, 1, 1'b1));
        send_box(box_at(-10, -10, -10, 2, 2, 1'b1));      // behind the origin: empty scan
        send_box(box_at(20, 20, 20, 2, 2, 1'b0));
        send_box(box_at(5, 5, 5, 2, 3, 1'b0));
        send_box(box_at(30, 30, 30, 2, 4, 1'b1));
        send_box(box_at(0, 0, 0, 4, 5, 1'b1));            // origin inside: entry is negative
        send_box(box_at(3, 3, 3, 2, 0, 1'b1));            // zero id still counts as a hit
        send_box(box_at(7, 7, 7, 0, 6, 1'b1));            // flat box
        send_box(mk_box(Q_MAX, Q_MAX, Q_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX, 16'hFFFF, 1'b0));
        send_box(mk_box(Q_MIN, Q_MIN, Q_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX, 16'h8000, 1'b1));
        send_box(box_at(8, 8, 8, 2, 7, 1'b0));
        send_box(box_at(8, 8, 8, 2, 8, 1'b1));            // tie keeps the first box
        send_box(box_at(2000, 2000, 2000, 2, 9, 1'b1));   // past max distance
    endtask

    task automatic test_ray_registers();
        load_ray(32'sh7FFF_FFFF, 32'sh8000_0000, '0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh8000_0001, 31'h7FFF_FFFF);
        send_box(box_at(0, 0, 0, 4, 11, 1'b0));
        send_box(mk_box(Q_MIN, Q_MAX, Q_MIN, SIZE_MAX, 0, SIZE_MAX, 12, 1'b0));
        send_box(box_at(100, -100, 5, 10, 13, 1'b1));
        // zero max distance rejects everything
        load_ray('0, '0, '0, RECIP_RESET, RECIP_RESET, RECIP_RESET, '0);
        send_box(box_at(10, 10, 10, 2, 14, 1'b1));
        // a max distance write inside an open scan applies from the next scan on
        load_ray('0, '0, '0, RECIP_RESET, RECIP_RESET, RECIP_RESET, MAX_DIST_RESET);
        send_box(box_at(50, 50, 50, 2, 15, 1'b0));
        settle();
        cfg_write(REG_MAX_DISTANCE, 10 * 65536);
        send_box(box_at(60, 60, 60, 2, 16, 1'b1));
        send_box(box_at(50, 50, 50, 2, 17, 1'b1));
        load_ray('0, '0, '0, -RECIP_RESET, -RECIP_RESET, -RECIP_RESET, MAX_DIST_RESET);
        send_box(box_at(-10, -10, -10, 2, 18, 1'b1));
    endtask

    task automatic test_random_scans(input int idle_pct, input int stall_pct, input int n);
        int sent, len, k;
        bit reloaded;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        sent       = 0;
        reloaded   = 1'b0;
        pick_ray();
        while (sent < n) begin
            if (!reloaded && sent >= n / 2) begin
                pick_ray();
                reloaded = 1'b1;
            end
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++)
                send_box(random_box(k == len - 1));
            sent += len;
        end
    endtask

    // hold the next scan until the previous result is out
    task automatic test_drained_scans();
        int s, k, len;
        send_idle  = 27;
        recv_stall = 27;
        pick_ray();
        for (s = 0; s < 8; s++) begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++)
                send_box(random_box(k == len - 1));
            wait_drained();
        end
    endtask

    always @(posedge aclk) begin : result_check
        nearest_t want;
        if (m_tvalid && m_tready) begin
            if (nearest_q.size() == 0) begin
                report_mismatch("unexpected result", longint'(m_tdata), 0);
            end else begin
                want = nearest_q.pop_front();
                if (m_tdata[15:0] !== want.id)
                    report_mismatch("nearest_id", longint'(m_tdata[15:0]), longint'(want.id));
                if (m_tdata[46:16] !== want.distance)
                    report_mismatch("nearest_distance", longint'(m_tdata[46:16]),
                                    longint'(want.distance));
                if (m_tuser !== want.hit)
                    report_mismatch("hit_found", longint'(m_tuser), longint'(want.hit));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pwrite)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int a = 0; a < 3; a++) begin
            ray_origin[a] = longint'(ORIGIN_RESET);
            ray_recip[a]  = longint'(RECIP_RESET);
        end
        ray_max_dist = longint'(MAX_DIST_RESET);
        best_dist    = ray_max_dist;
        best_id      = '0;
        scan_open    = 1'b0;
        hit_seen     = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_ray();
        test_ray_registers();
        test_random_scans(0, 0, 320);
        test_random_scans(66, 0, 320);
        test_random_scans(0, 66, 320);
        test_random_scans(27, 27, 320);
        test_drained_scans();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rbch_pkg.sv
rtl/rbch_cfg_regs.sv
rtl/rbch_slab.sv
rtl/rbch_nearest.sv
rtl/ray_box_closest_hit.sv
sim/testbench.sv
